// File: sv/gfcr_pkg.sv
package gfcr_pkg;

  // Default frame geometry.
  localparam int DEF_MAX_SRC_W = 160;
  localparam int DEF_MAX_SRC_H = 120;
  localparam int DEF_CROP_SIZE = 96;

  // Field widths fixed by the interface.
  localparam int PIX_W      = 8;
  localparam int SRC_DIM_W  = 8;
  localparam int DST_DIM_W  = 10;
  localparam int CHAN_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int QUOT_W     = 8;
  localparam int PROD_W     = DST_DIM_W + SRC_DIM_W;
  localparam int IDX_W      = PROD_W + 1;

  localparam logic [DST_DIM_W-1:0] ROW_MAX = '1;
  localparam logic [PIX_W-1:0]     PIX_BIAS = 8'h80;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_IS_GRAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_CHANNELS = 3'd5;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_BAD_CHANNELS = 3'd1,
    STATUS_NOT_GRAY     = 3'd2,
    STATUS_BAD_SIZE     = 3'd3,
    STATUS_INCOMPLETE   = 3'd4,
    STATUS_NO_PIXELS    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ADDR,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PIX_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_out;
    status_t                 status;
    logic                    last_pixel;
  } result_t;

endpackage

// File: sv/gfcr_ram.sv
module gfcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/gray_frame_crop_resample_int8.sv
// Load, start and unused items are taken at once while idle; loads sustain one per cycle while no read is in progress.
// A read goes through a check step that reports a failed check; a crop or pass-through
// pixel then takes an address and a read step, and a resampled pixel first runs two 8-step
// restoring dividers side by side; the next item is taken once the block is back in idle.
// Reset is synchronous: it clears the counters and restores the register defaults.
// The frame store has no reset and no clearing pass.
module gray_frame_crop_resample_int8 import gfcr_pkg::*; #(
  parameter int MAX_SRC_W = DEF_MAX_SRC_W,
  parameter int MAX_SRC_H = DEF_MAX_SRC_H,
  parameter int CROP_SIZE = DEF_CROP_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_SRC_W * MAX_SRC_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIDX_W = $clog2(DEPTH + 1);
  localparam int OFF_X  = (MAX_SRC_W >= CROP_SIZE) ? (MAX_SRC_W - CROP_SIZE) / 2 : 0;
  localparam int OFF_Y  = (MAX_SRC_H >= CROP_SIZE) ? (MAX_SRC_H - CROP_SIZE) / 2 : 0;

  // Configuration registers.
  logic [SRC_DIM_W-1:0] src_width;
  logic [SRC_DIM_W-1:0] src_height;
  logic                 src_is_gray;
  logic [DST_DIM_W-1:0] dst_width;
  logic [DST_DIM_W-1:0] dst_height;
  logic [CHAN_W-1:0]    dst_channels;

  state_t state;
  state_t state_next;

  logic [LIDX_W-1:0]    load_index;
  logic [DST_DIM_W-1:0] out_col;
  logic [DST_DIM_W-1:0] out_row;

  logic [DST_DIM_W-1:0] rem_x;
  logic [DST_DIM_W-1:0] rem_y;
  logic [QUOT_W-1:0]    quot_x;
  logic [QUOT_W-1:0]    quot_y;
  logic [2:0]           div_cnt;

  logic [ADDR_W-1:0]    rd_addr;
  logic                 idx_ok;
  logic                 last_flag;
  logic [PIX_W-1:0]     rd_data;

  logic item_take;
  logic result_free;
  logic ram_we;
  logic ram_re;
  logic emit_err;
  logic emit_pix;
  logic div_start;

  logic                 big_src;
  logic                 small_src;
  logic                 crop_mode;
  logic [2*SRC_DIM_W:0] frame_px;
  status_t              status_chk;

  logic [PROD_W-1:0]    num_x;
  logic [PROD_W-1:0]    num_y;
  logic [DST_DIM_W:0]   trial_x;
  logic [DST_DIM_W:0]   trial_y;
  logic [DST_DIM_W-1:0] sx_sel;
  logic [DST_DIM_W-1:0] sy_sel;
  logic [IDX_W-1:0]     idx;

  assign cfg_ready   = 1'b1;
  assign item_take   = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;

  // Frame checks, evaluated on the already wrapped position.
  always_comb begin
    big_src   = (src_width == SRC_DIM_W'(MAX_SRC_W)) && (src_height == SRC_DIM_W'(MAX_SRC_H));
    small_src = (src_width == SRC_DIM_W'(CROP_SIZE)) && (src_height == SRC_DIM_W'(CROP_SIZE));
    crop_mode = (dst_width == DST_DIM_W'(CROP_SIZE)) && (dst_height == DST_DIM_W'(CROP_SIZE));
    frame_px  = (2*SRC_DIM_W+1)'(src_width) * (2*SRC_DIM_W+1)'(src_height);
    if (dst_channels != CHAN_W'(1)) begin
      status_chk = STATUS_BAD_CHANNELS;
    end else if (!src_is_gray) begin
      status_chk = STATUS_NOT_GRAY;
    end else if (!(big_src || small_src)) begin
      status_chk = STATUS_BAD_SIZE;
    end else if ((2*SRC_DIM_W+1)'(load_index) < frame_px) begin
      status_chk = STATUS_INCOMPLETE;
    end else if (dst_width == '0 || dst_height == '0 || out_row >= dst_height) begin
      status_chk = STATUS_NO_PIXELS;
    end else begin
      status_chk = STATUS_OK;
    end
  end

  // Divider operands and one restoring step per lane.
  always_comb begin
    num_x   = PROD_W'(out_col) * PROD_W'(src_width);
    num_y   = PROD_W'(out_row) * PROD_W'(src_height);
    trial_x = {rem_x, quot_x[QUOT_W-1]};
    trial_y = {rem_y, quot_y[QUOT_W-1]};
  end

  // Source coordinate and flat store index.
  always_comb begin
    if (crop_mode) begin
      if (small_src) begin
        sx_sel = out_col;
        sy_sel = out_row;
      end else begin
        sx_sel = DST_DIM_W'(OFF_X) + out_col;
        sy_sel = DST_DIM_W'(OFF_Y) + out_row;
      end
    end else begin
      sx_sel = DST_DIM_W'(quot_x);
      sy_sel = DST_DIM_W'(quot_y);
    end
    idx = IDX_W'(sy_sel) * IDX_W'(src_width) + IDX_W'(sx_sel);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_take && item.opcode == OP_READ) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (result_free) begin
          if (status_chk != STATUS_OK) begin
            state_next = ST_IDLE;
          end else if (crop_mode) begin
            state_next = ST_ADDR;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == '1) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        if (result_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    item_stall = (state != ST_IDLE);
    ram_we     = item_take && item.opcode == OP_LOAD && load_index < LIDX_W'(DEPTH);
    ram_re     = (state == ST_ADDR);
    emit_err   = (state == ST_CHECK) && result_free && status_chk != STATUS_OK;
    div_start  = (state == ST_CHECK) && result_free && status_chk == STATUS_OK && !crop_mode;
    emit_pix   = (state == ST_READ) && result_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      src_width    <= SRC_DIM_W'(DEF_MAX_SRC_W);
      src_height   <= SRC_DIM_W'(DEF_MAX_SRC_H);
      src_is_gray  <= 1'b1;
      dst_width    <= DST_DIM_W'(DEF_CROP_SIZE);
      dst_height   <= DST_DIM_W'(DEF_CROP_SIZE);
      dst_channels <= CHAN_W'(1);
      load_index   <= '0;
      out_col      <= '0;
      out_row      <= '0;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_WIDTH:    src_width    <= cfg_data[SRC_DIM_W-1:0];
          CFG_SRC_HEIGHT:   src_height   <= cfg_data[SRC_DIM_W-1:0];
          CFG_SRC_IS_GRAY:  src_is_gray  <= cfg_data[0];
          CFG_DST_WIDTH:    dst_width    <= cfg_data[DST_DIM_W-1:0];
          CFG_DST_HEIGHT:   dst_height   <= cfg_data[DST_DIM_W-1:0];
          CFG_DST_CHANNELS: dst_channels <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (emit_err || emit_pix) begin
        result_valid <= 1'b1;
      end

      if (item_take) begin
        case (item.opcode)
          OP_START: begin
            load_index <= '0;
            out_col    <= '0;
            out_row    <= '0;
          end
          OP_LOAD: begin
            if (load_index < LIDX_W'(DEPTH)) begin
              load_index <= load_index + 1'b1;
            end
          end
          OP_READ: begin
            // A target that shrank during readout wraps the column first.
            if (dst_width != '0 && out_col >= dst_width) begin
              out_col <= '0;
              if (out_row < ROW_MAX) begin
                out_row <= out_row + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      if (div_start) begin
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end

      if (state == ST_ADDR) begin
        if (out_col + 1'b1 >= dst_width) begin
          out_col <= '0;
          if (out_row < ROW_MAX) begin
            out_row <= out_row + 1'b1;
          end
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (div_start) begin
      rem_x  <= num_x[PROD_W-1:QUOT_W];
      quot_x <= num_x[QUOT_W-1:0];
      rem_y  <= num_y[PROD_W-1:QUOT_W];
      quot_y <= num_y[QUOT_W-1:0];
    end else if (state == ST_DIV) begin
      if (trial_x >= {1'b0, dst_width}) begin
        rem_x  <= DST_DIM_W'(trial_x - {1'b0, dst_width});
        quot_x <= {quot_x[QUOT_W-2:0], 1'b1};
      end else begin
        rem_x  <= trial_x[DST_DIM_W-1:0];
        quot_x <= {quot_x[QUOT_W-2:0], 1'b0};
      end
      if (trial_y >= {1'b0, dst_height}) begin
        rem_y  <= DST_DIM_W'(trial_y - {1'b0, dst_height});
        quot_y <= {quot_y[QUOT_W-2:0], 1'b1};
      end else begin
        rem_y  <= trial_y[DST_DIM_W-1:0];
        quot_y <= {quot_y[QUOT_W-2:0], 1'b0};
      end
    end

    if (state == ST_ADDR) begin
      idx_ok    <= idx < IDX_W'(DEPTH);
      last_flag <= ({1'b0, out_row} + 1'b1 == {1'b0, dst_height}) &&
                   ({1'b0, out_col} + 1'b1 == {1'b0, dst_width});
    end

    if (emit_err) begin
      result.pixel_out  <= '0;
      result.status     <= status_chk;
      result.last_pixel <= 1'b0;
    end else if (emit_pix) begin
      result.pixel_out  <= idx_ok ? (rd_data ^ PIX_BIAS) : PIX_BIAS;
      result.status     <= STATUS_OK;
      result.last_pixel <= last_flag;
    end
  end

  assign rd_addr = idx[ADDR_W-1:0];

  gfcr_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(load_index[ADDR_W-1:0]),
    .wdata(item.pixel_in),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // The store read issued in the address step must land right before its result.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> ($past(state) == ST_ADDR || $past(state) == ST_READ))
    else $error("read step entered without an address step");

  assert property (@(posedge clk) disable iff (rst)
    load_index <= LIDX_W'(DEPTH))
    else $error("load index ran past the frame store");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_pixel |-> result.status == STATUS_OK)
    else $error("last pixel flagged on a failed read");

  assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> item_stall)
    else $error("item taken while a read is in progress");

endmodule

// File: test/tb_gray_frame_crop_resample_int8.sv
`timescale 1ns / 100ps

module tb_gray_frame_crop_resample_int8;
  import gfcr_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_SRC_W * DEF_MAX_SRC_H;
  localparam int CROP_X = (DEF_MAX_SRC_W - DEF_CROP_SIZE) / 2;
  localparam int CROP_Y = (DEF_MAX_SRC_H - DEF_CROP_SIZE) / 2;
  localparam int DST_MAX = 1023;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    item_t                 it;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    has_want;
    result_t               want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block: registers, frame store and read position.
  logic [SRC_DIM_W-1:0] m_src_w = SRC_DIM_W'(DEF_MAX_SRC_W);
  logic [SRC_DIM_W-1:0] m_src_h = SRC_DIM_W'(DEF_MAX_SRC_H);
  logic                 m_gray = 1'b1;
  logic [DST_DIM_W-1:0] m_dst_w = DST_DIM_W'(DEF_CROP_SIZE);
  logic [DST_DIM_W-1:0] m_dst_h = DST_DIM_W'(DEF_CROP_SIZE);
  logic [CHAN_W-1:0]    m_chan = CHAN_W'(1);
  logic [14:0]          m_loaded = '0;
  logic [DST_DIM_W-1:0] m_col = '0;
  logic [DST_DIM_W-1:0] m_row = '0;
  logic [PIX_W-1:0]     pix_store [STORE_DEPTH];

  result_t  due_pixels [$];
  result_t  want_r;
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       cycle_count = 0;
  bit       calm = 1'b0;

  gray_frame_crop_resample_int8 i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_gray_frame_crop_resample_int8 NOT OK");
      $finish;
    end
  end

  function automatic item_t mk_item(input logic [1:0] op, input logic [PIX_W-1:0] pix);
    item_t it;
    it.opcode = op;
    it.pixel_in = pix;
    return it;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return PIX_W'($urandom);
  endfunction

  function automatic dir_row_t row_item(input logic [1:0] op, input logic [PIX_W-1:0] pix);
    dir_row_t r;
    r = '{ROW_ITEM, mk_item(op, pix), '0, '0, 1'b0, '0};
    return r;
  endfunction

  // A read whose answer is a bare status code.
  function automatic dir_row_t row_read(input status_t st);
    dir_row_t r;
    result_t  w;
    w.pixel_out = '0;
    w.status = st;
    w.last_pixel = 1'b0;
    r = '{ROW_ITEM, mk_item(OP_READ, 8'h5A), '0, '0, 1'b1, w};
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{ROW_CFG, '0, idx, data, 1'b0, '0};
    return r;
  endfunction

  // Applies one item to the shadow copy and yields the pixel it produces, if any.
  task automatic resample_step(input item_t it, output bit has_res, output result_t r);
    int       sx, sy, idx;
    bit       full_frame, square;
    status_t  st;
    logic [PIX_W-1:0] v;
    has_res = 1'b0;
    r = '0;
    case (it.opcode)
      OP_START: begin
        m_loaded = '0;
        m_col = '0;
        m_row = '0;
      end
      OP_LOAD: begin
        if (int'(m_loaded) < STORE_DEPTH) begin
          pix_store[m_loaded] = it.pixel_in;
          m_loaded = m_loaded + 1'b1;
        end
      end
      OP_READ: begin
        has_res = 1'b1;
        // A column left past a shrunken target wraps before anything is checked.
        if (m_dst_w != 0 && m_col >= m_dst_w) begin
          m_col = '0;
          if (int'(m_row) < DST_MAX) m_row = m_row + 1'b1;
        end
        full_frame = (m_src_w == DEF_MAX_SRC_W) && (m_src_h == DEF_MAX_SRC_H);
        square = (m_src_w == DEF_CROP_SIZE) && (m_src_h == DEF_CROP_SIZE);
        st = STATUS_OK;
        v = '0;
        if (m_chan != 1) st = STATUS_BAD_CHANNELS;
        else if (!m_gray) st = STATUS_NOT_GRAY;
        else if (!(full_frame || square)) st = STATUS_BAD_SIZE;
        else if (int'(m_loaded) < int'(m_src_w) * int'(m_src_h)) st = STATUS_INCOMPLETE;
        else if (m_dst_w == 0 || m_dst_h == 0 || m_row >= m_dst_h) st = STATUS_NO_PIXELS;
        if (st == STATUS_OK) begin
          if (m_dst_w == DEF_CROP_SIZE && m_dst_h == DEF_CROP_SIZE) begin
            sx = square ? int'(m_col) : CROP_X + int'(m_col);
            sy = square ? int'(m_row) : CROP_Y + int'(m_row);
          end else begin
            sx = int'(m_col) * int'(m_src_w) / int'(m_dst_w);
            sy = int'(m_row) * int'(m_src_h) / int'(m_dst_h);
          end
          idx = sy * int'(m_src_w) + sx;
          v = (idx < STORE_DEPTH) ? pix_store[idx] : '0;
          v = v ^ PIX_BIAS;
          r.last_pixel = (int'(m_row) + 1 == int'(m_dst_h)) &&
                         (int'(m_col) + 1 == int'(m_dst_w));
          m_col = m_col + 1'b1;
          if (m_col >= m_dst_w) begin
            m_col = '0;
            if (int'(m_row) < DST_MAX) m_row = m_row + 1'b1;
          end
        end
        r.pixel_out = v;
        r.status = st;
      end
      default: ;
    endcase
  endtask

  // Drives one item and, once it transfers, records the pixel it is due to produce.
  task automatic push_item(input item_t it, input bit has_want = 1'b0,
                           input result_t want = '0);
    int      gap;
    bit      got;
    result_t r;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    resample_step(it, got, r);
    if (got) due_pixels.push_back(has_want ? want : r);
  endtask

  // Holds the sender back until every pixel due has come out, then lets the block settle.
  task automatic drain_reads();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:    m_src_w = data[SRC_DIM_W-1:0];
      CFG_SRC_HEIGHT:   m_src_h = data[SRC_DIM_W-1:0];
      CFG_SRC_IS_GRAY:  m_gray = data[0];
      CFG_DST_WIDTH:    m_dst_w = data[DST_DIM_W-1:0];
      CFG_DST_HEIGHT:   m_dst_h = data[DST_DIM_W-1:0];
      CFG_DST_CHANNELS: m_chan = data[CHAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int sw, input int sh, input int gray,
                              input int dw, input int dh, input int ch);
    drain_reads();
    write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
    write_reg(CFG_SRC_IS_GRAY, CFG_DATA_W'(gray));
    write_reg(CFG_DST_WIDTH, CFG_DATA_W'(dw));
    write_reg(CFG_DST_HEIGHT, CFG_DATA_W'(dh));
    write_reg(CFG_DST_CHANNELS, CFG_DATA_W'(ch));
  endtask

  // Mostly reads, with unused codes and stray loads mixed in.
  task automatic read_round(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        push_item(mk_item($urandom_range(0, 1) ? OP_UNUSED : OP_LOAD, rand_pixel()));
      end else begin
        push_item(mk_item(OP_READ, rand_pixel()));
      end
    end
  endtask

  // Loads one frame, then reads it out under a string of target sizes.
  task automatic run_frame(input bit full_size, input bit whole_readout, input bit tall);
    int sw, sh, nload, dw, dh, ch, gray, n, v;
    bit short_load;
    sw = full_size ? DEF_MAX_SRC_W : DEF_CROP_SIZE;
    sh = full_size ? DEF_MAX_SRC_H : DEF_CROP_SIZE;
    calm = ($urandom_range(0, 3) == 0);
    set_geometry(sw, sh, 1, DEF_CROP_SIZE, DEF_CROP_SIZE, 1);
    push_item(mk_item(OP_START, rand_pixel()));
    short_load = !whole_readout && ($urandom_range(0, 2) == 0);
    // On a full-size source the extra loads land on a full store and are dropped.
    nload = sw * sh + $urandom_range(0, 3);
    for (int i = 0; i < nload; i++) begin
      if (short_load && i == sw * sh - 1) push_item(mk_item(OP_READ, rand_pixel()));
      push_item(mk_item(OP_LOAD, rand_pixel()));
    end
    calm = ($urandom_range(0, 3) == 0);
    read_round(whole_readout ? DEF_CROP_SIZE * DEF_CROP_SIZE + 2 : $urandom_range(40, 250));
    for (int rnd = 0; rnd < 4 + int'(tall); rnd++) begin
      calm = ($urandom_range(0, 3) == 0);
      ch = 1;
      gray = 1;
      v = (rnd == 4) ? 9 : $urandom_range(0, 7);
      case (v)
        0: begin
          dw = DST_MAX;
          dh = int'(m_row) + $urandom_range(1, 2);
          n = $urandom_range(50, 300);
        end
        1: begin
          dw = $urandom_range(1, 3);
          dh = DST_MAX;
          n = $urandom_range(30, 100);
        end
        2: begin
          if ($urandom_range(0, 1)) begin
            dw = 0;
            dh = $urandom_range(0, DST_MAX);
          end else begin
            dw = $urandom_range(1, DST_MAX);
            dh = 0;
          end
          n = 3;
        end
        3: begin
          ch = $urandom_range(0, 15);
          gray = (ch == 1) ? 0 : $urandom_range(0, 1);
          dw = $urandom_range(1, 24);
          dh = $urandom_range(1, 24);
          n = 3;
        end
        9: begin
          // One pixel per row all the way down to the last row the target allows.
          dw = 1;
          dh = DST_MAX;
          n = DST_MAX - int'(m_row) + 3;
        end
        default: begin
          dw = $urandom_range(1, 24);
          dh = int'(m_row) + $urandom_range(1, 8);
          if (dh > DST_MAX) dh = DST_MAX;
          n = dw * (dh - int'(m_row)) + $urandom_range(0, 3);
        end
      endcase
      if (dh > DST_MAX) dh = DST_MAX;
      set_geometry(sw, sh, gray, dw, dh, ch);
      read_round(n);
    end
    calm = 1'b0;
    for (int i = 0; i < 30; i++) begin
      push_item(mk_item(2'($urandom_range(0, 3)), rand_pixel()));
    end
  endtask

  // Result side: a random hold-off before each transfer, none at all in calm stretches.
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_pixels.size() == 0) begin
        $display("%0t ns: unexpected pixel, expected none, got %0d status %0d last %0b",
                 $time, result.pixel_out, result.status, result.last_pixel);
        errors = errors + 1;
      end else begin
        want_r = due_pixels.pop_front();
        if (result.pixel_out !== want_r.pixel_out) begin
          $display("%0t ns: pixel_out expected %0d, got %0d",
                   $time, want_r.pixel_out, result.pixel_out);
          errors = errors + 1;
        end
        if (result.status !== want_r.status) begin
          $display("%0t ns: status expected %0d, got %0d", $time, want_r.status, result.status);
          errors = errors + 1;
        end
        if (result.last_pixel !== want_r.last_pixel) begin
          $display("%0t ns: last_pixel expected %0b, got %0b",
                   $time, want_r.last_pixel, result.last_pixel);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    dir_rows = '{
      row_read(STATUS_INCOMPLETE),                 // nothing loaded after reset
      row_item(OP_UNUSED, 8'hFF),
      row_read(STATUS_INCOMPLETE),
      row_cfg(CFG_DST_CHANNELS, 10'd0),
      row_read(STATUS_BAD_CHANNELS),
      row_cfg(CFG_DST_CHANNELS, 10'd15),
      row_cfg(CFG_SRC_IS_GRAY, 10'd0),
      row_read(STATUS_BAD_CHANNELS),               // channel count is checked first
      row_cfg(CFG_DST_CHANNELS, 10'd1),
      row_read(STATUS_NOT_GRAY),
      row_cfg(CFG_SRC_WIDTH, 10'd255),
      row_read(STATUS_NOT_GRAY),                   // format wins over size
      row_cfg(CFG_SRC_IS_GRAY, 10'd1),
      row_read(STATUS_BAD_SIZE),
      row_cfg(CFG_SRC_WIDTH, 10'd0),
      row_cfg(CFG_SRC_HEIGHT, 10'd255),
      row_read(STATUS_BAD_SIZE),
      row_cfg(CFG_SRC_WIDTH, 10'd96),
      row_read(STATUS_BAD_SIZE),
      row_cfg(CFG_SRC_HEIGHT, 10'd96),
      row_item(OP_LOAD, 8'h00),
      row_item(OP_LOAD, 8'hFF),
      row_read(STATUS_INCOMPLETE),
      row_item(OP_START, 8'hA5),
      row_cfg(CFG_DST_WIDTH, 10'd0),
      row_read(STATUS_INCOMPLETE),                 // incomplete frame ranks above empty target
      row_cfg(CFG_DST_HEIGHT, 10'd1023),
      row_read(STATUS_INCOMPLETE)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_reads();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_item(dir_rows[i].it, dir_rows[i].has_want, dir_rows[i].want);
      end
    end
    run_frame(1'b0, 1'b1, 1'b0);
    run_frame(1'b1, 1'b1, 1'b0);
    run_frame(1'b1, 1'b0, 1'b1);
    run_frame(1'b0, 1'b0, 1'b0);
    run_frame(1'b1, 1'b0, 1'b0);
    run_frame(1'b0, 1'b0, 1'b1);
    drain_reads();
    if (errors == 0) begin
      $display("tb_gray_frame_crop_resample_int8 OK");
    end else begin
      $display("tb_gray_frame_crop_resample_int8 NOT OK");
    end
    $finish;
  end

endmodule

// File: gray_frame_crop_resample_int8.f
sv/gfcr_pkg.sv
sv/gfcr_ram.sv
sv/gray_frame_crop_resample_int8.sv
test/tb_gray_frame_crop_resample_int8.sv
